FILE: design/rbpb_pkg.sv
package rbpb_pkg;

  localparam int MapWidth   = 256;
  localparam int MapHeight  = 256;
  localparam int MaxRadius  = 63;
  localparam int XW         = $clog2(MapWidth);
  localparam int YW         = $clog2(MapHeight);
  localparam int AddrW      = XW + YW;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STAMP = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  localparam logic [0:0] CFG_TOOL   = 1'b0;
  localparam logic [0:0] CFG_RADIUS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_SQRT,
    ST_DIV,
    ST_WEIGHT,
    ST_MIX,
    ST_OUT
  } state_t;

endpackage

FILE: design/radial_brush_pixel_blend.sv
// Channel | Direction | Handshake      | Payload
// in      | input     | in_valid/stall | action, pos_x, pos_y, in_red/green/blue, strength
// out     | output    | out_valid/stall| out_red, out_green, out_blue, painted_count
// cfg     | input     | cfg_we         | cfg_index, cfg_data (tool_select, radius)
//
// Cycles: one item at a time. Write, read or idle action: the result is valid
// two edges after the input transfer, three cycles per item. Stamp: one setup
// cycle, one per window pixel off the disc or the map, 52 per pixel on the disc
// (walk, 25 square root, 24 restoring divide, weight, read-modify-write), then
// one for the result. Reset clears control state only; the map stays undefined.
// A stalled result holds the output register; the next input transfer waits.
module radial_brush_pixel_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [15:0] strength,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [13:0] painted_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import rbpb_pkg::*;

  logic [23:0] mem [MapWidth*MapHeight];
  logic [23:0] rd_data;
  logic        mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [23:0] mem_wdata;

  logic [2:0]  tool;
  logic [6:0]  radius;

  state_t state, state_next;

  logic [1:0]  act;
  logic [7:0]  cx, cy;
  logic [15:0] str;
  logic [6:0]  h;
  logic [6:0]  reach;
  logic signed [8:0] dx, dy;
  logic [13:0] count;
  logic [23:0] color;

  // square root: root of d2<<34, d2 <= 2*63^2 fits 13 bits -> 47-bit value
  logic [47:0] sq_v, sq_root, sq_bit;
  logic [23:0] dividend;  // (h<<16)-s
  logic [23:0] quot;
  logic [6:0]  rem;
  logic [4:0]  step;
  logic [15:0] wgt;

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      tool   <= 3'd0;
      radius <= 7'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOOL:   tool   <= cfg_data[2:0];
        CFG_RADIUS: radius <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE) || out_valid;

  logic signed [9:0] px, py;
  logic        pin;
  logic [13:0] d2;
  assign px  = $signed({2'b0, cx}) + 10'(dx);
  assign py  = $signed({2'b0, cy}) + 10'(dy);
  assign pin = (px >= 0) && (px < MapWidth) && (py >= 0) && (py < MapHeight);
  assign d2  = 14'(dx*dx + dy*dy);

  logic [13:0] hh;
  assign hh = 14'(h * h);

  // on the map and strictly inside the disc: 4*d2 < h*h, kept at 16 bits
  logic        in_disc;
  assign in_disc = pin && ({d2, 2'b00} < {2'b00, hh});

  // quotient reaches 65536 at the center pixel, so keep 17 bits
  logic [32:0] wmul;
  assign wmul = quot[16:0] * str;

  function automatic logic [7:0] mixc(input logic [7:0] c, input logic [7:0] o,
                                      input logic [15:0] w);
    logic [24:0] t;
    t = 25'(c * w) + 25'(o * (17'h10000 - 17'(w)));
    return t[23:16];
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid && !in_stall) begin
        unique case (action_t'(action))
          ACT_STAMP: state_next = ST_SETUP;
          ACT_NOP:   state_next = ST_OUT;
          default:   state_next = ST_OUT;
        endcase
      end
      ST_SETUP: state_next = (tool >= 3'd1 && tool <= 3'd3) ? ST_WALK : ST_OUT;
      ST_WALK:  begin
        if (in_disc) state_next = ST_SQRT;
        else if (dx == 9'(reach) && dy == 9'(reach)) state_next = ST_OUT;
      end
      ST_SQRT:   if (sq_bit == 48'd0) state_next = ST_DIV;
      ST_DIV:    if (step == 5'd0) state_next = ST_WEIGHT;
      ST_WEIGHT: state_next = ST_MIX;
      ST_MIX:    state_next = (dx == 9'(reach) && dy == 9'(reach)) ? ST_OUT : ST_WALK;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {py[YW-1:0], px[XW-1:0]};
    mem_wdata = {mixc(color[23:16], rd_data[23:16], wgt),
                 mixc(color[15:8], rd_data[15:8], wgt),
                 mixc(color[7:0], rd_data[7:0], wgt)};
    if (state == ST_IDLE) begin
      mem_addr  = {pos_y[YW-1:0], pos_x[XW-1:0]};
      mem_wdata = {in_red, in_green, in_blue};
      mem_we    = in_valid && !in_stall && action == ACT_WRITE;
    end else if (state == ST_MIX) begin
      mem_we = wgt != 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_OUT) out_valid <= 1'b1;
    end
    unique case (state)
      ST_IDLE: if (in_valid && !in_stall) begin
        act <= action; cx <= pos_x; cy <= pos_y; str <= strength;
        count <= '0;
        h <= (radius == 7'd0) ? 7'd1 : radius;
      end
      ST_SETUP: begin
        reach <= (h[6:1] > 6'(MaxRadius)) ? 7'(MaxRadius) : {1'b0, h[6:1]};
        dx <= -9'(h[6:1]); dy <= -9'(h[6:1]);
        unique case (tool)
          3'd2:    color <= 24'h0000FF;
          3'd3:    color <= 24'h00FF00;
          default: color <= 24'h000000;
        endcase
        sq_bit <= '0;
      end
      ST_WALK: begin
        if (in_disc) begin
          sq_v <= {d2, 34'b0};
          sq_root <= '0;
          sq_bit <= 48'h4000_0000_0000 >> 0;
        end else if (dx == 9'(reach)) begin
          dx <= -9'(reach); dy <= dy + 9'sd1;
        end else dx <= dx + 9'sd1;
      end
      ST_SQRT: begin
        if (sq_bit != '0) begin
          if (sq_v >= sq_root + sq_bit) begin
            sq_v <= sq_v - (sq_root + sq_bit);
            sq_root <= (sq_root >> 1) + sq_bit;
          end else sq_root <= sq_root >> 1;
          sq_bit <= sq_bit >> 2;
        end else begin
          dividend <= 24'({h, 16'b0}) - 24'(sq_root);
          quot <= '0; rem <= '0; step <= 5'd23;
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        begin
          logic [7:0] r2;
          r2 = {rem, dividend[step]};
          if (r2 >= {1'b0, h}) begin
            rem <= 7'(r2 - {1'b0, h}); quot[step] <= 1'b1;
          end else begin
            rem <= r2[6:0]; quot[step] <= 1'b0;
          end
          if (step != 0) step <= step - 5'd1;
        end
      end
      ST_MIX: begin
        if (wgt != 0) count <= count + 14'd1;
        if (dx == 9'(reach)) begin
          dx <= -9'(reach); dy <= dy + 9'sd1;
        end else dx <= dx + 9'sd1;
      end
      ST_OUT: begin
        out_red <= '0; out_green <= '0; out_blue <= '0; painted_count <= '0;
        if (act == ACT_READ) begin
          out_red <= rd_data[23:16]; out_green <= rd_data[15:8];
          out_blue <= rd_data[7:0];
        end else if (act == ACT_STAMP) painted_count <= count;
      end
      default: ;
    endcase
  end

  // weight registered ahead of the mix so the RAM read of the pixel lands too
  always_ff @(posedge clk) begin
    if (state == ST_WEIGHT) wgt <= wmul[31:16];
  end

endmodule

FILE: design/rbpb_checker.sv
module rbpb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [13:0] painted_count,
  input logic [7:0] out_red
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(painted_count))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result waits");
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("no stall after transfer");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && painted_count != 0 |-> out_red == 0)
    else $error("read and stamp outputs mixed");
endmodule

bind radial_brush_pixel_blend rbpb_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .painted_count(painted_count), .out_red(out_red));
